// ===== src/apa_pkg.sv =====
// Shared types and fixed-point constants of the vector angle block.
package apa_pkg;

  localparam int unsigned QuotBits = 15;

  localparam logic [17:0] Tan3Pi8Q16 = 18'd158217;
  localparam logic [17:0] TanPi8Q16  = 18'd27145;

  localparam logic signed [19:0] K4Q16 = 20'sd5278;
  localparam logic signed [19:0] K3Q16 = 20'sd9095;
  localparam logic signed [19:0] K2Q16 = 20'sd13093;
  localparam logic signed [19:0] K1Q16 = 20'sd21845;

  localparam logic signed [20:0] Pi4Q16   = 21'sd51472;
  localparam logic signed [20:0] Pi2Q16   = 21'sd102944;
  localparam logic signed [20:0] PiQ16    = 21'sd205887;
  localparam logic signed [20:0] Pi32Q16  = 21'sd308831;
  localparam logic signed [20:0] TwoPiQ16 = 21'sd411775;

  localparam logic [31:0] TwoPiQ24 = 32'd105414357;

  typedef enum logic [1:0] {
    OFF_ZERO = 2'd0,
    OFF_PI4  = 2'd1,
    OFF_PI2  = 2'd2
  } offset_e;

  typedef struct packed {
    logic    x_neg;
    logic    y_neg;
    logic    x_zero;
    logic    y_zero;
    logic    t_neg;
    offset_e offset;
  } ctl_t;

  function automatic logic signed [47:0] round_shr(input logic signed [47:0] v,
                                                   input int unsigned s);
    logic signed [47:0] half;
    half = 48'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end else begin
      return -((-v + half) >>> s);
    end
  endfunction

endpackage

// ===== src/apa_if.sv =====
// Valid/ready channel interfaces for the vector input and the angle output.
interface apa_vec_if #(
  parameter int unsigned CW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] vec_x;
  logic signed [CW-1:0] vec_y;

  modport source (output valid, output vec_x, output vec_y, input ready);
  modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

interface apa_angle_if #(
  parameter int unsigned AW = 16
);
  logic          valid;
  logic          ready;
  logic [AW-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

// ===== src/apa_front.sv =====
// Front end: folds the vector to the first quadrant and picks the reduction.
module apa_front import apa_pkg::*; #(
  parameter int unsigned CW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  apa_vec_if.sink           in_if,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [CW:0]       num_o,
  output logic [CW:0]       den_o,
  output ctl_t              ctl_o
);

  logic          valid_q;
  logic [CW:0]   num_q, num_d, den_q, den_d;
  ctl_t          ctl_q, ctl_d;
  logic [CW-1:0] ax, ay;
  logic [CW+17:0] ay_sh, hi_rhs, mid_rhs;
  logic          take;

  assign in_if.ready = !valid_q || ready_i;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    ax      = in_if.vec_x[CW-1] ? (~in_if.vec_x + 1'b1) : in_if.vec_x;
    ay      = in_if.vec_y[CW-1] ? (~in_if.vec_y + 1'b1) : in_if.vec_y;
    ay_sh   = {2'b00, ay, 16'h0000};
    hi_rhs  = (CW+18)'(Tan3Pi8Q16) * (CW+18)'(ax);
    mid_rhs = (CW+18)'(TanPi8Q16) * (CW+18)'(ax);
    ctl_d.x_neg  = in_if.vec_x[CW-1];
    ctl_d.y_neg  = in_if.vec_y[CW-1];
    ctl_d.x_zero = (in_if.vec_x == '0);
    ctl_d.y_zero = (in_if.vec_y == '0);
    if (ay_sh > hi_rhs) begin
      ctl_d.offset = OFF_PI2;
      ctl_d.t_neg  = 1'b1;
      num_d        = {1'b0, ax};
      den_d        = {1'b0, ay};
    end else if (ay_sh > mid_rhs) begin
      ctl_d.offset = OFF_PI4;
      ctl_d.t_neg  = (ay < ax);
      num_d        = (ay < ax) ? {1'b0, ax - ay} : {1'b0, ay - ax};
      den_d        = {1'b0, ay} + {1'b0, ax};
    end else begin
      ctl_d.offset = OFF_ZERO;
      ctl_d.t_neg  = 1'b0;
      num_d        = {1'b0, ay};
      den_d        = {1'b0, ax};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_if.ready) begin
      valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      num_q <= num_d;
      den_q <= den_d;
      ctl_q <= ctl_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign ctl_o   = ctl_q;

endmodule

// ===== src/apa_fifo.sv =====
// Two-entry queue that decouples the front end from the arithmetic pipeline.
module apa_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/apa_back.sv =====
// Back end: pipelined divider, polynomial evaluation and quadrant restore.
module apa_back import apa_pkg::*; #(
  parameter int unsigned CW  = 16,
  parameter int unsigned AFB = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [CW:0] num_i,
  input  logic [CW:0] den_i,
  input  ctl_t        ctl_i,
  apa_angle_if.source out_if
);

  localparam int unsigned DW = CW + 1;
  localparam int unsigned AW = AFB + 3;
  localparam logic [31:0] Ceil = TwoPiQ24 >> (24 - AFB);

  logic adv;

  logic          dv_q   [QuotBits];
  logic [DW-1:0] rem_q  [QuotBits];
  logic [DW-1:0] den_q  [QuotBits];
  logic [QuotBits-1:0] quo_q [QuotBits];
  ctl_t          dctl_q [QuotBits];

  logic                 zv_q, p1v_q, p2v_q, p3v_q, p4v_q, fv_q, ov_q;
  ctl_t                 zc_q, p1c_q, p2c_q, p3c_q, p4c_q, fc_q;
  logic signed [15:0]   zt_q, p1t_q, p2t_q, p3t_q, p4t_q;
  logic signed [17:0]   z_q, p1z_q, p2z_q, p3z_q;
  logic signed [19:0]   p1_q, p2_q, p3_q, p4_q;
  logic signed [20:0]   a_q;
  logic [AW-1:0]        angle_q;

  assign adv     = !ov_q || out_if.ready;
  assign ready_o = adv;

  for (genvar k = 0; k < QuotBits; k++) begin : g_div
    logic [DW-1:0]       rem_in, den_in;
    logic [QuotBits-1:0] quo_in;
    logic                v_in;
    ctl_t                c_in;
    logic [DW:0]         sh;
    logic                ge;
    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign v_in   = valid_i;
      assign c_in   = ctl_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign v_in   = dv_q[k-1];
      assign c_in   = dctl_q[k-1];
    end
    assign sh = {rem_in, 1'b0};
    assign ge = (sh >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (adv) begin
        dv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k]  <= ge ? DW'(sh - {1'b0, den_in}) : DW'(sh);
        den_q[k]  <= den_in;
        quo_q[k]  <= {quo_in[QuotBits-2:0], ge};
        dctl_q[k] <= c_in;
      end
    end
  end

  logic signed [15:0] t_d;
  logic signed [31:0] t32, tt;
  logic signed [39:0] m1, m2, m3, m4;
  logic signed [47:0] m5;
  logic signed [20:0] off_val, r_s;
  logic [19:0]        r_u;
  logic [31:0]        r_w, r_o;

  always_comb begin
    t_d = dctl_q[QuotBits-1].t_neg ? -$signed({1'b0, quo_q[QuotBits-1]})
                                   : $signed({1'b0, quo_q[QuotBits-1]});
    t32 = 32'(t_d);
    tt  = t32 * t32;
    m1  = 40'(K4Q16) * 40'(z_q);
    m2  = 40'(p1_q) * 40'(p1z_q);
    m3  = 40'(p2_q) * 40'(p2z_q);
    m4  = 40'(p3_q) * 40'(p3z_q);
    m5  = 48'(p4_q) * 48'(p4t_q);
    case (p4c_q.offset)
      OFF_ZERO: off_val = '0;
      OFF_PI4:  off_val = Pi4Q16;
      OFF_PI2:  off_val = Pi2Q16;
      default:  off_val = '0;
    endcase
    if (fc_q.x_zero) begin
      r_s = fc_q.y_zero ? '0 : (fc_q.y_neg ? Pi32Q16 : Pi2Q16);
    end else if (!fc_q.x_neg) begin
      r_s = fc_q.y_neg ? TwoPiQ16 - a_q : a_q;
    end else begin
      r_s = fc_q.y_neg ? PiQ16 + a_q : PiQ16 - a_q;
    end
    r_u = r_s[20] ? '0 : r_s[19:0];
    r_w = 32'(r_u);
  end

  if (AFB < 16) begin : g_round
    assign r_o = (r_w + (32'd1 << (15 - AFB))) >> (16 - AFB);
  end else begin : g_scale
    assign r_o = r_w << (AFB - 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zv_q  <= 1'b0;
      p1v_q <= 1'b0;
      p2v_q <= 1'b0;
      p3v_q <= 1'b0;
      p4v_q <= 1'b0;
      fv_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else if (adv) begin
      zv_q  <= dv_q[QuotBits-1];
      p1v_q <= zv_q;
      p2v_q <= p1v_q;
      p3v_q <= p2v_q;
      p4v_q <= p3v_q;
      fv_q  <= p4v_q;
      ov_q  <= fv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zc_q    <= dctl_q[QuotBits-1];
      zt_q    <= t_d;
      z_q     <= 18'(round_shr(48'(tt), 14));
      p1c_q   <= zc_q;
      p1t_q   <= zt_q;
      p1z_q   <= z_q;
      p1_q    <= 20'(round_shr(48'(m1), 16)) - K3Q16;
      p2c_q   <= p1c_q;
      p2t_q   <= p1t_q;
      p2z_q   <= p1z_q;
      p2_q    <= 20'(round_shr(48'(m2), 16)) + K2Q16;
      p3c_q   <= p2c_q;
      p3t_q   <= p2t_q;
      p3z_q   <= p2z_q;
      p3_q    <= 20'(round_shr(48'(m3), 16)) - K1Q16;
      p4c_q   <= p3c_q;
      p4t_q   <= p3t_q;
      p4_q    <= 20'(round_shr(48'(m4), 16));
      fc_q    <= p4c_q;
      a_q     <= off_val + 21'(p4t_q) * 21'sd2 + 21'(round_shr(m5, 15));
      angle_q <= (r_o > Ceil) ? AW'(Ceil) : AW'(r_o);
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.angle = angle_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (32'(angle_q) <= Ceil))
    else $error("Angle above the top of the range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(fv_q) && $stable(p4v_q) && $stable(zv_q))
    else $error("Pipeline moved while the output was stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[QuotBits-1] && !dctl_q[QuotBits-1].x_zero)
      |-> (rem_q[QuotBits-1] < den_q[QuotBits-1]))
    else $error("Divider remainder not below the divisor.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    zv_q |-> (z_q >= 0) && (z_q <= 18'sd65536))
    else $error("Squared argument out of range.");

endmodule

// ===== src/atan2_polynomial_angle.sv =====
// Top level of the vector angle block: front end, queue and arithmetic pipeline.
// Takes one signed vector per cycle while the output is not stalled and returns its
// angle from 0 to 2*pi in units of 2^-ANGLE_FRAC_BITS radian. From an accepted input to
// its result the data passes one front-end register, the queue, fifteen divider stages
// producing one quotient bit each, and seven stages for the square, the four polynomial
// steps, the offset sum and the quadrant and rounding stage. Throughput is one transaction
// per cycle while the output is not stalled; the zero vector returns 0 and the y axis
// returns pi/2 or 3pi/2.
module atan2_polynomial_angle import apa_pkg::*; #(
  parameter int unsigned COORD_WIDTH     = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  apa_vec_if.sink     in_if,
  apa_angle_if.source out_if
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned QW = $bits(ctl_t) + 2 * DW;

  logic          fr_valid, fr_ready, q_valid, q_ready;
  logic [DW-1:0] fr_num, fr_den, q_num, q_den;
  ctl_t          fr_ctl, q_ctl;
  logic [QW-1:0] q_data;

  apa_front #(.CW(COORD_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .num_o   (fr_num),
    .den_o   (fr_den),
    .ctl_o   (fr_ctl)
  );

  apa_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  ({fr_ctl, fr_num, fr_den}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign q_ctl = q_data[QW-1 -: $bits(ctl_t)];
  assign q_num = q_data[2*DW-1 -: DW];
  assign q_den = q_data[DW-1:0];

  apa_back #(.CW(COORD_WIDTH), .AFB(ANGLE_FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ready_o (q_ready),
    .num_i   (q_num),
    .den_i   (q_den),
    .ctl_i   (q_ctl),
    .out_if  (out_if)
  );

endmodule
